// File: rtl/sbfh_pkg.sv
// ----------------------------------------------------------------------------
// sbfh_pkg
// Shared types and constants for the sparse-bigram feature hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sbfh_pkg;

	localparam int HASH_W      = 32;
	localparam int DIST_W      = 4;
	localparam int COEF_W      = 12;
	localparam int COEF_N      = 10;
	localparam int OUT_TDATA_W = 72;   // 32 + 32 + 4, padded to whole bytes
	localparam int CFG_IDX_W   = 2;

	localparam logic [HASH_W-1:0] FILLER_HASH = 32'hDEAD_BEEF;

	// command codes on the input tuser
	localparam logic CMD_TOKEN = 1'b0;
	localparam logic CMD_END   = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAD_AFTER_END = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMPAT_COEF   = 2'd1;

	localparam logic [COEF_W-1:0] COEF_A [COEF_N] = '{
		12'd1, 12'd3, 12'd5, 12'd11, 12'd23, 12'd47, 12'd97, 12'd197, 12'd397, 12'd797
	};
	localparam logic [COEF_W-1:0] COEF_B [COEF_N] = '{
		12'd7, 12'd13, 12'd29, 12'd51, 12'd101, 12'd203, 12'd407, 12'd817, 12'd1637,
		12'd3277
	};

	// one feature pair request from the window sequencer
	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] newest;
		logic [HASH_W-1:0] older;
		logic [DIST_W-1:0] pair_dist;
		logic              last;
	} feat_req_t;

endpackage

`default_nettype wire

// File: rtl/sbfh_seq.sv
// ----------------------------------------------------------------------------
// sbfh_seq
// Hash window and distance sequencer: shifts hashes in, walks the distances
// and runs the filler passes at end of document.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfh_seq #(
	parameter int WINDOW_LEN = 5
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      in_cmd,
	input  wire logic [sbfh_pkg::HASH_W-1:0] in_hash,
	input  wire logic                      pad_en,
	input  wire logic                      out_free,
	output sbfh_pkg::feat_req_t            req
);
	import sbfh_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_LEN);
	localparam logic [CNT_W-1:0] DIST_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] DIST_MAX  = CNT_W'(WINDOW_LEN - 1);
	localparam logic [CNT_W-1:0] PAD_START = CNT_W'(WINDOW_LEN - 2);

	logic [HASH_W-1:0] win_q [WINDOW_LEN];
	logic [HASH_W-1:0] base  [WINDOW_LEN];
	logic              busy_q;
	logic              end_mode_q;
	logic [CNT_W-1:0]  dist_q;
	logic [CNT_W-1:0]  pads_q;

	logic              fire;
	logic              at_end;
	logic              item_done;
	logic              in_fire;
	logic              rearm_now;
	logic [HASH_W-1:0] shift_val;

	assign fire      = busy_q && out_free;
	assign at_end    = (dist_q == DIST_MAX);
	assign item_done = fire && at_end && (pads_q == '0);
	assign in_ready  = !busy_q || item_done;
	assign in_fire   = in_valid && in_ready;
	assign rearm_now = item_done && end_mode_q;
	assign shift_val = (in_cmd == CMD_TOKEN) ? in_hash : FILLER_HASH;

	// window as seen by an item accepted in the same cycle the last one ends
	always_comb begin
		for (int i = 0; i < WINDOW_LEN; i++) begin
			base[i] = rearm_now ? FILLER_HASH : win_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= FILLER_HASH;
			end
		end else begin
			priority if (in_fire) begin
				if (in_cmd == CMD_END && !pad_en) begin
					for (int i = 0; i < WINDOW_LEN; i++) begin
						win_q[i] <= FILLER_HASH;
					end
				end else begin
					win_q[0] <= shift_val;
					for (int i = 1; i < WINDOW_LEN; i++) begin
						win_q[i] <= base[i-1];
					end
				end
			end else if (fire && at_end && pads_q != '0) begin
				win_q[0] <= FILLER_HASH;
				for (int i = 1; i < WINDOW_LEN; i++) begin
					win_q[i] <= win_q[i-1];
				end
			end else if (rearm_now) begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					win_q[i] <= FILLER_HASH;
				end
			end else begin
				// window holds
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			end_mode_q <= 1'b0;
			dist_q     <= DIST_ONE;
			pads_q     <= '0;
		end else begin
			priority if (in_fire) begin
				busy_q     <= !(in_cmd == CMD_END && !pad_en);
				end_mode_q <= (in_cmd == CMD_END);
				dist_q     <= DIST_ONE;
				pads_q     <= (in_cmd == CMD_END) ? PAD_START : '0;
			end else if (fire) begin
				if (at_end) begin
					dist_q <= DIST_ONE;
					if (pads_q != '0) begin
						pads_q <= pads_q - DIST_ONE;
					end else begin
						busy_q     <= 1'b0;
						end_mode_q <= 1'b0;
					end
				end else begin
					dist_q <= dist_q + DIST_ONE;
				end
			end else begin
				// idle, or waiting on the output register
			end
		end
	end

	always_comb begin
		req.valid     = busy_q;
		req.newest    = win_q[0];
		req.older     = win_q[dist_q];
		req.pair_dist = DIST_W'(dist_q);
		req.last      = at_end && (pads_q == '0);
	end

endmodule

`default_nettype wire

// File: rtl/sbfh_feature.sv
// ----------------------------------------------------------------------------
// sbfh_feature
// Feature pair arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfh_feature (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sbfh_pkg::feat_req_t           req,
	input  wire logic                          compat,
	output logic                               out_free,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [sbfh_pkg::OUT_TDATA_W-1:0]   out_data,
	output logic                               out_last
);
	import sbfh_pkg::*;

	logic [DIST_W-1:0] coef_idx;
	logic [HASH_W-1:0] prim;
	logic [HASH_W-1:0] sec;
	logic              valid_q;
	logic [HASH_W-1:0] prim_q;
	logic [HASH_W-1:0] sec_q;
	logic [DIST_W-1:0] dist_q;
	logic              last_q;

	assign coef_idx = compat ? (req.pair_dist - DIST_W'(1)) : req.pair_dist;

	// products are kept modulo 2^32
	assign prim = HASH_W'(req.newest * HASH_W'(COEF_A[0]))
		+ HASH_W'(req.older * HASH_W'(COEF_A[req.pair_dist]));
	assign sec  = HASH_W'(req.newest * HASH_W'(COEF_B[0]))
		+ HASH_W'(req.older * HASH_W'(COEF_B[coef_idx]));

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && req.valid) begin
			prim_q <= prim;
			sec_q  <= sec;
			dist_q <= req.pair_dist;
			last_q <= req.last;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {(OUT_TDATA_W - 2*HASH_W - DIST_W)'(0), dist_q, sec_q, prim_q};
	assign out_last  = last_q;

endmodule

`default_nettype wire

// File: rtl/sparse_bigram_feature_hasher.sv
// Each item's first result reaches m_axis through the output register.
// Throughput: one result per cycle unless m_axis stalls; a token gives WINDOW_LEN-1
// results, an end of document (WINDOW_LEN-1)^2 with padding or none without, set by
// the distance sequencer that feeds the single feature unit one distance per cycle.
// Reset: window holds 0xDEADBEEF, padding on, compatible coefficients off, no result.
// ----------------------------------------------------------------------------
// sparse_bigram_feature_hasher
// Streams sparse-bigram feature hash pairs for a sliding window of token hashes.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_bigram_feature_hasher #(
	parameter int WINDOW_LEN = 5
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [sbfh_pkg::HASH_W-1:0]        s_axis_tdata,  // token_hash
	input  wire logic                               s_axis_tuser,  // cmd
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// primary_hash[31:0], secondary_hash[63:32], distance[67:64], zero pad
	output logic [sbfh_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	output logic                                    m_axis_tlast,  // last_feature
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sbfh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic                               cfg_data
);
	import sbfh_pkg::*;

	logic      pad_q;
	logic      compat_q;
	logic      out_free;
	feat_req_t req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q    <= 1'b1;
			compat_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_PAD_AFTER_END) begin
				pad_q <= cfg_data;
			end
			if (cfg_index == REG_COMPAT_COEF) begin
				compat_q <= cfg_data;
			end
		end
	end

	sbfh_seq #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_hash  (s_axis_tdata),
		.pad_en   (pad_q),
		.out_free (out_free),
		.req      (req)
	);

	sbfh_feature u_feature (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.compat    (compat_q),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: rtl/sbfh_checker.sv
// ----------------------------------------------------------------------------
// sbfh_checker
// Port-level checks for the sparse-bigram feature hasher.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfh_checker #(
	parameter int WINDOW_LEN = 5
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [sbfh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input wire logic                              m_axis_tlast
);
	import sbfh_pkg::*;

	localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(WINDOW_LEN - 1);

	logic [DIST_W-1:0] pair_dist;
	assign pair_dist = m_axis_tdata[2*HASH_W +: DIST_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_axis_tvalid) |-> $past(m_axis_tready))
		else $error("result dropped without handshake");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pair_dist != '0 && pair_dist <= DIST_MAX)
		else $error("distance out of range");

	a_last_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> pair_dist == DIST_MAX)
		else $error("last feature not at the widest distance");

endmodule

bind sparse_bigram_feature_hasher sbfh_checker #(
	.WINDOW_LEN(WINDOW_LEN)
) u_sbfh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: bench/sparse_bigram_feature_hasher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_bigram_feature_hasher_test
// Self-checking bench for the sparse-bigram feature hasher. A stimulus table
// covers reset state, hash extremes, document ends with and without padding
// and both coefficient tables; then random documents run under every register
// setting. Each feature pair is predicted from a private copy of the hash
// window and compared in order with the output stream. Both stream sides idle
// at random, and the output side holds off once long enough to stall the input.
// ----------------------------------------------------------------------------

module sparse_bigram_feature_hasher_test;

	localparam int WIN_LEN      = 5;
	localparam int MAX_FEATURES = (WIN_LEN - 1) * (WIN_LEN - 1);
	localparam int DRAIN_PAD    = 8;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 36;
	localparam int PLAN_LEN     = 26;

	localparam logic [31:0] FILL_HASH = 32'hDEAD_BEEF;

	// multipliers per window distance, entry 0 in the low bits
	localparam logic [9:0][11:0] MUL_P = {
		12'd797, 12'd397, 12'd197, 12'd97, 12'd47, 12'd23, 12'd11, 12'd5, 12'd3, 12'd1
	};
	localparam logic [9:0][11:0] MUL_S = {
		12'd3277, 12'd1637, 12'd817, 12'd407, 12'd203, 12'd101, 12'd51, 12'd29, 12'd13, 12'd7
	};

	localparam logic ROW_ITEM = 1'b0;
	localparam logic ROW_CFG  = 1'b1;

	// indexes past the register map, writes there must change nothing
	localparam logic [sbfh_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [sbfh_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	typedef struct packed {
		logic [sbfh_pkg::HASH_W-1:0] primary_hash;
		logic [sbfh_pkg::HASH_W-1:0] secondary_hash;
		logic [sbfh_pkg::DIST_W-1:0] distance;
		logic                        last_feature;
	} feature_t;

	typedef struct packed {
		logic                           kind;
		logic                           cmd;
		logic [sbfh_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [31:0]                    data;     // token hash, or register value in bit 0
		logic                           typed;    // first pair given below
		logic [31:0]                    want_p;
		logic [31:0]                    want_s;
	} step_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [sbfh_pkg::HASH_W-1:0]         s_axis_tdata  = '0;
	logic                                s_axis_tuser  = sbfh_pkg::CMD_TOKEN;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [sbfh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
	logic                                m_axis_tlast;
	logic                                cfg_valid     = 1'b0;
	logic                                cfg_ready;
	logic [sbfh_pkg::CFG_IDX_W-1:0]      cfg_index     = sbfh_pkg::REG_PAD_AFTER_END;
	logic                                cfg_data      = 1'b0;

	// predictor state
	logic [31:0] hist [WIN_LEN];
	logic        pad_on    = 1'b1;
	logic        compat_on = 1'b0;
	feature_t    batch [MAX_FEATURES];
	feature_t    feature_q [$];

	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  results_seen   = 0;
	int  reg_writes     = 0;
	int  cycle_count    = 0;
	int  hold_left      = 0;
	bit  hold_started   = 0;
	bit  calm           = 0;

	step_t plan [PLAN_LEN] = '{
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'h0000_0000, 1'b1, 32'h9C09_3CCD, 32'h4ED2_B223},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF9},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFD, 32'hFFFF_FFF3},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'h5555_5555, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'h1234_5678, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_END,   2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
		// empty document: padding runs over filler only
		'{ROW_ITEM, sbfh_pkg::CMD_END,   2'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
		'{ROW_CFG,  sbfh_pkg::CMD_TOKEN, sbfh_pkg::REG_COMPAT_COEF, 32'h1, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_END,   2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
		'{ROW_CFG,  sbfh_pkg::CMD_TOKEN, sbfh_pkg::REG_PAD_AFTER_END, 32'h0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'hDEAD_BEEF, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
		// ends without padding give nothing but still re-arm the window
		'{ROW_ITEM, sbfh_pkg::CMD_END,   2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_END,   2'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
		'{ROW_CFG,  sbfh_pkg::CMD_TOKEN, REG_UNMAPPED_LO, 32'h0, 1'b0, 32'h0, 32'h0},
		'{ROW_CFG,  sbfh_pkg::CMD_TOKEN, REG_UNMAPPED_HI, 32'h1, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_END,   2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
		'{ROW_CFG,  sbfh_pkg::CMD_TOKEN, sbfh_pkg::REG_PAD_AFTER_END, 32'h1, 1'b0, 32'h0, 32'h0},
		'{ROW_CFG,  sbfh_pkg::CMD_TOKEN, sbfh_pkg::REG_COMPAT_COEF, 32'h0, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_TOKEN, 2'd0, 32'hC3C3_C3C3, 1'b0, 32'h0, 32'h0},
		'{ROW_ITEM, sbfh_pkg::CMD_END,   2'd0, 32'h0000_0000, 1'b0, 32'h0, 32'h0}
	};

	sparse_bigram_feature_hasher #(
		.WINDOW_LEN(WIN_LEN)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// shift one hash into the window and lay its pairs into batch from slot base
	function automatic int shift_in(logic [31:0] h, logic closes_item, int base);
		int       i;
		int       d;
		int       k;
		feature_t f;
		for (i = WIN_LEN - 1; i > 0; i--)
			hist[i] = hist[i - 1];
		hist[0] = h;
		for (d = 1; d < WIN_LEN; d++) begin
			k = compat_on ? d - 1 : d;
			f.primary_hash   = hist[0] * MUL_P[0] + hist[d] * MUL_P[d];
			f.secondary_hash = hist[0] * MUL_S[0] + hist[d] * MUL_S[k];
			f.distance       = d[sbfh_pkg::DIST_W-1:0];
			f.last_feature   = closes_item && (d == WIN_LEN - 1);
			batch[base + d - 1] = f;
		end
		return base + WIN_LEN - 1;
	endfunction

	function automatic int hash_features(logic cmd, logic [31:0] h);
		int n;
		int cnt;
		cnt = 0;
		if (cmd == sbfh_pkg::CMD_TOKEN) begin
			cnt = shift_in(h, 1'b1, cnt);
		end else begin
			if (pad_on)
				for (n = 0; n < WIN_LEN - 1; n++)
					cnt = shift_in(FILL_HASH, n == WIN_LEN - 2, cnt);
			for (n = 0; n < WIN_LEN; n++)
				hist[n] = FILL_HASH;
		end
		return cnt;
	endfunction

	function automatic void flag_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns: %s", $time, what);
	endfunction

	function automatic logic [31:0] pick_hash();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 32'h0000_0000;
		else if (r < 16)
			return 32'hFFFF_FFFF;
		else if (r < 20)
			return FILL_HASH;
		return $urandom;
	endfunction

	// offer one item; valid stays high on return so back-to-back items need no toggle
	task automatic send_item(input logic cmd, input logic [31:0] h, input step_t row);
		int cnt;
		int n;
		while (!calm && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= h;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		cnt = hash_features(cmd, h);
		if (row.typed && cnt > 0) begin
			batch[0].primary_hash   = row.want_p;
			batch[0].secondary_hash = row.want_s;
		end
		for (n = 0; n < cnt; n++)
			feature_q.push_back(batch[n]);
	endtask

	// stop offering and wait for the pipeline to empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (feature_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sbfh_pkg::CFG_IDX_W-1:0] idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == sbfh_pkg::REG_PAD_AFTER_END)
			pad_on = val;
		else if (idx == sbfh_pkg::REG_COMPAT_COEF)
			compat_on = val;
		@(posedge clk);
	endtask

	// output side: random stalls, plus one long hold-off once traffic is flowing
	always @(posedge clk) begin
		if (!hold_started && items_sent >= HOLD_AT) begin
			hold_started = 1;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 20);
		end
	end

	always @(posedge clk) begin : watch_results
		feature_t got;
		feature_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			got.primary_hash   = m_axis_tdata[31:0];
			got.secondary_hash = m_axis_tdata[63:32];
			got.distance       = m_axis_tdata[67:64];
			got.last_feature   = m_axis_tlast;
			if (feature_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected pair p=%h s=%h d=%0d last=%b",
					got.primary_hash, got.secondary_hash, got.distance,
					got.last_feature));
			end else begin
				want = feature_q.pop_front();
				if (got != want || m_axis_tdata[71:68] != 4'd0)
					flag_mismatch($sformatf(
						"pair mismatch: want p=%h s=%h d=%0d last=%b, got p=%h s=%h d=%0d last=%b pad=%h",
						want.primary_hash, want.secondary_hash, want.distance,
						want.last_feature, got.primary_hash, got.secondary_hash,
						got.distance, got.last_feature, m_axis_tdata[71:68]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pairs outstanding", cycle_count,
				feature_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int    i;
		int    ph;
		int    j;
		int    doc_len;
		int    in_phase;
		logic  pad_sel;
		logic  compat_sel;
		step_t row;
		step_t blank;

		blank = '0;
		for (i = 0; i < WIN_LEN; i++)
			hist[i] = FILL_HASH;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_LEN; i++) begin
			row = plan[i];
			if (row.kind == ROW_CFG) begin
				settle();
				write_reg(row.reg_idx, row.data[0]);
			end else begin
				send_item(row.cmd, row.data, row);
			end
		end

		for (ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: begin pad_sel = 1'b1; compat_sel = 1'b1; end
				1: begin pad_sel = 1'b0; compat_sel = 1'b0; end
				2: begin pad_sel = 1'b1; compat_sel = 1'b0; end
				3: begin pad_sel = 1'b0; compat_sel = 1'b1; end
				default: begin
					pad_sel    = 1'($urandom_range(1));
					compat_sel = 1'($urandom_range(1));
				end
			endcase
			write_reg(sbfh_pkg::REG_PAD_AFTER_END, pad_sel);
			write_reg(sbfh_pkg::REG_COMPAT_COEF, compat_sel);
			if (ph >= 4)
				write_reg($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
					1'($urandom_range(1)));
			calm     = (ph == 2);
			in_phase = 0;
			while (in_phase < PHASE_ITEMS) begin
				// mostly documents of random tokens closed by one end, some stray ends
				doc_len = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 7);
				for (j = 0; j < doc_len; j++) begin
					send_item(sbfh_pkg::CMD_TOKEN, pick_hash(), blank);
					in_phase++;
				end
				send_item(sbfh_pkg::CMD_END, $urandom, blank);
				in_phase++;
				if ($urandom_range(99) < 10) begin
					send_item(sbfh_pkg::CMD_END, $urandom, blank);
					in_phase++;
				end
				// once, midway through phase 1: let the whole pipeline run dry before going on
				if (ph == 1 && in_phase >= PHASE_ITEMS / 2 && in_phase < PHASE_ITEMS / 2 + 8) begin
					settle();
					in_phase = PHASE_ITEMS / 2 + 8;
				end
			end
		end
		calm = 0;
		settle();

		$display("ran %0d items, %0d feature pairs checked, %0d register writes",
			items_sent, results_seen, reg_writes);
		$display("padding and coefficient table in all four settings, one %0d-cycle output stall",
			HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
